// ===== rtl/keyed_record_table_top_macros.svh =====
// Assertion macros for the keyed record table top level.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef KEYED_RECORD_TABLE_TOP_MACROS_SVH
`define KEYED_RECORD_TABLE_TOP_MACROS_SVH

// cons must hold in the same cycle as ante
`define KRT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define KRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/krt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the keyed record table.
// No dependencies; used by krt_cell and keyed_record_table_top.
package krt_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int WIDE_W      = CNT_W + 8;

    localparam int CMD_W       = 3;
    localparam int KEY_W       = 32;
    localparam int ENTRY_IDX_W = 7;
    localparam int AGE_W       = 8;
    localparam int PAY_W       = 64;
    localparam int STATUS_W    = 2;
    localparam int HIT_W       = 7;
    localparam int COUNT_OUT_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 3'd0,
        CMD_SEARCH = 3'd1,
        CMD_UPDATE = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_READ   = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ROTATE,
        CELL_WRITE,
        CELL_UPDATE,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [AGE_W-1:0]        age;
        logic [PAY_W-1:0]        payload;
    } cell_data_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] pos;
        cell_data_t       data;
    } cell_bus_t;

endpackage

// ===== rtl/keyed_record_table_top.sv =====
`timescale 1ns / 1ps
// Keyed record table: controller plus a ring of TABLE_DEPTH record cells.
// Depends on krt_pkg, krt_cell and keyed_record_table_top_macros.svh.
`include "keyed_record_table_top_macros.svh"

// Keyed record table of TABLE_DEPTH records (key, age, payload), filled from
// position 0 with no gaps. One transaction is worked at a time; in_stall is
// high from acceptance until the result is loaded into the output register.
// Add and unused commands go straight to the apply state; search, update,
// delete and read first rotate the cells one full turn of the ring, one
// place per cycle, while the controller looks at cell 0 for the first match
// (or the asked position). After the scan, update and delete are applied in
// the apply state: the target cell rewrites itself, or every cell from the
// target upward takes its upper neighbor. The next transaction can be taken
// once the result is loaded. A result waiting at the output does not keep
// the next transaction from being accepted.
module keyed_record_table_top
    import krt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [CMD_W-1:0]        cmd,
    input  logic signed [KEY_W-1:0] key,
    input  logic [ENTRY_IDX_W-1:0]  entry_index,
    input  logic [AGE_W-1:0]        age_in,
    input  logic [PAY_W-1:0]        payload_in,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [STATUS_W-1:0]     status,
    output logic [HIT_W-1:0]        hit_index,
    output logic signed [KEY_W-1:0] key_out,
    output logic [AGE_W-1:0]        age_out,
    output logic [PAY_W-1:0]        payload_out,
    output logic [COUNT_OUT_W-1:0]  entry_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_EMIT
    } state_t;

    state_t                   state_reg, state_next;
    cmd_t                     cmd_reg, cmd_next;
    logic signed [KEY_W-1:0]  key_reg, key_next;
    logic [ENTRY_IDX_W-1:0]   idx_reg, idx_next;
    logic [AGE_W-1:0]         age_reg, age_next;
    logic [PAY_W-1:0]         pay_reg, pay_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [IDX_W-1:0]         step_reg, step_next;
    logic                     found_reg, found_next;

    status_t                  res_status_reg, res_status_next;
    logic [IDX_W-1:0]         res_pos_reg, res_pos_next;
    cell_data_t               res_data_reg, res_data_next;

    logic                     out_valid_reg, out_valid_next;
    status_t                  out_status_reg, out_status_next;
    logic [HIT_W-1:0]         out_hit_reg, out_hit_next;
    cell_data_t               out_data_reg, out_data_next;
    logic [COUNT_OUT_W-1:0]   out_count_reg, out_count_next;

    cell_bus_t                cell_bus;
    cell_data_t               cell_data [TABLE_DEPTH];
    cell_data_t               head;
    logic                     step_live;
    logic                     head_hit;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        krt_cell u_cell (
            .clk        (clk),
            .cell_index (IDX_W'(i)),
            .bus        (cell_bus),
            .nbr        (cell_data[(i + 1) % TABLE_DEPTH]),
            .data       (cell_data[i])
        );
    end

    // During the scan, cell 0 holds the entry at position step_reg
    assign head      = cell_data[0];
    assign step_live = WIDE_W'(step_reg) < WIDE_W'(count_reg);
    assign head_hit  = (cmd_reg == CMD_READ) ? (WIDE_W'(step_reg) == WIDE_W'(idx_reg))
                                             : (head.key == key_reg);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        age_next        = age_reg;
        pay_next        = pay_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        found_next      = found_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_data_next   = res_data_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_hit_next    = out_hit_reg;
        out_data_next   = out_data_reg;
        out_count_next  = out_count_reg;

        cell_bus.op           = CELL_HOLD;
        cell_bus.pos          = res_pos_reg;
        cell_bus.data.key     = key_reg;
        cell_bus.data.age     = age_reg;
        cell_bus.data.payload = pay_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = cmd_t'(cmd);
                    key_next        = key;
                    idx_next        = entry_index;
                    age_next        = age_in;
                    pay_next        = payload_in;
                    step_next       = '0;
                    found_next      = 1'b0;
                    res_status_next = ST_RANGE;
                    res_pos_next    = '0;
                    res_data_next   = '0;
                    if (cmd_t'(cmd) == CMD_SEARCH || cmd_t'(cmd) == CMD_UPDATE ||
                        cmd_t'(cmd) == CMD_DELETE || cmd_t'(cmd) == CMD_READ)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_APPLY;
                    end
                end
            end
            S_SCAN:
            begin
                cell_bus.op = CELL_ROTATE;
                step_next   = step_reg + IDX_W'(1);
                if (!found_reg && step_live && head_hit)
                begin
                    found_next    = 1'b1;
                    res_pos_next  = step_reg;
                    res_data_next = head;
                    if (cmd_reg == CMD_UPDATE)
                    begin
                        res_data_next.age     = age_reg;
                        res_data_next.payload = pay_reg;
                    end
                end
                // the last rotate puts every record back in its home cell
                if (step_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                state_next = S_EMIT;
                unique case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (count_reg == CNT_W'(TABLE_DEPTH))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            cell_bus.op           = CELL_WRITE;
                            cell_bus.pos          = IDX_W'(count_reg);
                            count_next            = count_reg + CNT_W'(1);
                            res_status_next       = ST_OK;
                            res_pos_next          = IDX_W'(count_reg);
                            res_data_next.key     = key_reg;
                            res_data_next.age     = age_reg;
                            res_data_next.payload = pay_reg;
                        end
                    end
                    CMD_SEARCH, CMD_UPDATE, CMD_DELETE:
                    begin
                        if (found_reg)
                        begin
                            res_status_next = ST_OK;
                            if (cmd_reg == CMD_UPDATE)
                            begin
                                cell_bus.op = CELL_UPDATE;
                            end
                            else if (cmd_reg == CMD_DELETE)
                            begin
                                cell_bus.op = CELL_SHIFT;
                                count_next  = count_reg - CNT_W'(1);
                            end
                        end
                        else
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    CMD_READ:
                    begin
                        if (found_reg)
                        begin
                            res_status_next = ST_OK;
                        end
                        else
                        begin
                            res_status_next = ST_RANGE;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_RANGE;
                    end
                endcase
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_hit_next    = HIT_W'(res_pos_reg);
                    out_data_next   = res_data_reg;
                    out_count_next  = COUNT_OUT_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= CMD_ADD;
            key_reg        <= '0;
            idx_reg        <= '0;
            age_reg        <= '0;
            pay_reg        <= '0;
            count_reg      <= '0;
            step_reg       <= '0;
            found_reg      <= 1'b0;
            res_status_reg <= ST_OK;
            res_pos_reg    <= '0;
            res_data_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_hit_reg    <= '0;
            out_data_reg   <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            key_reg        <= key_next;
            idx_reg        <= idx_next;
            age_reg        <= age_next;
            pay_reg        <= pay_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            found_reg      <= found_next;
            res_status_reg <= res_status_next;
            res_pos_reg    <= res_pos_next;
            res_data_reg   <= res_data_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_hit_reg    <= out_hit_next;
            out_data_reg   <= out_data_next;
            out_count_reg  <= out_count_next;
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign hit_index   = out_hit_reg;
    assign key_out     = out_data_reg.key;
    assign age_out     = out_data_reg.age;
    assign payload_out = out_data_reg.payload;
    assign entry_count = out_count_reg;

    `KRT_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH), "fill count past depth")
    `KRT_ASSERT_NEXT(a_count_only_apply, state_reg != S_APPLY, $stable(count_reg), "count moved outside apply")
    `KRT_ASSERT_NEXT(a_scan_ends, state_reg == S_SCAN && step_reg == IDX_W'(TABLE_DEPTH - 1), state_reg == S_APPLY, "ring turn not closed")
    `KRT_ASSERT_NEXT(a_out_from_emit, state_reg != S_EMIT && !out_valid_reg, !out_valid_reg, "result without emit")

endmodule

// ===== rtl/krt_cell.sv =====
`timescale 1ns / 1ps
// One table cell: holds a record and takes its neighbor's record on rotate or shift.
// Depends on krt_pkg.
module krt_cell
    import krt_pkg::*;
(
    input  logic             clk,
    input  logic [IDX_W-1:0] cell_index,
    input  cell_bus_t        bus,
    input  cell_data_t       nbr,
    output cell_data_t       data
);

    cell_data_t data_reg;
    cell_data_t data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (bus.op)
            CELL_HOLD:
            begin
                data_next = data_reg;
            end
            CELL_ROTATE:
            begin
                data_next = nbr;
            end
            CELL_WRITE:
            begin
                if (cell_index == bus.pos)
                begin
                    data_next = bus.data;
                end
            end
            CELL_UPDATE:
            begin
                if (cell_index == bus.pos)
                begin
                    data_next.age     = bus.data.age;
                    data_next.payload = bus.data.payload;
                end
            end
            CELL_SHIFT:
            begin
                // everything at and above the removed slot moves down one
                if (cell_index >= bus.pos)
                begin
                    data_next = nbr;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
